// ===== rtl/rno_pkg.sv =====
// shared types, codes and calendar helpers for the next-occurrence core
// no dependencies; used by every module in rtl/
package rno_pkg;

    // recurrence rule codes
    typedef enum logic [1:0] {
        RULE_NONE    = 2'd0,
        RULE_DAILY   = 2'd1,
        RULE_WEEKLY  = 2'd2,
        RULE_MONTHLY = 2'd3
    } t_rule;

    localparam logic [13:0] MAX_YEAR    = 14'd9999;
    localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
    localparam logic [10:0] RECIP_25    = 11'd1311;   // 2^15 / 25, rounded up
    localparam logic [14:0] WK_BIAS     = 15'd168;    // multiple of 7, keeps the sum positive

    // one side of a query after the first stage
    typedef struct packed {
        logic [13:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        logic [26:0] ms;
        logic [7:0]  q100;
        logic [5:0]  q400;
    } t_side;

    typedef struct packed {
        logic        ok_pre;
        t_rule       rule;
        logic        later;
        logic        mon_after;
        logic        tod_gt;
        t_side       s;
        t_side       a;
    } t_p1;

    typedef struct packed {
        logic        found;
        t_rule       rule;
        logic        later;
        logic        tod_gt;
        logic [13:0] sy;
        logic [3:0]  sm;
        logic [4:0]  sd;
        logic [26:0] sms;
        logic [13:0] ay;
        logic [3:0]  am;
        logic [4:0]  ad;
        logic [4:0]  ml_a;
        logic        leap_a;
        logic [14:0] wk_s;
        logic [14:0] wk_a;
        logic        mon_adv;
    } t_p2;

    typedef struct packed {
        logic        found;
        t_rule       rule;
        logic        later;
        logic [13:0] sy;
        logic [3:0]  sm;
        logic [4:0]  sd;
        logic [26:0] sms;
        logic [13:0] ay;
        logic [3:0]  am;
        logic [4:0]  ad;
        logic [4:0]  ml_a;
        logic        leap_a;
        logic [3:0]  delta;
        logic [13:0] ty;
        logic [3:0]  tm;
        logic        yr_inc;
    } t_p3;

    typedef struct packed {
        logic        found;
        logic [13:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        logic [26:0] ms;
    } t_res;

    // days in month, zero for a month code outside 1..12
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = leap ? 5'd29 : 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

    // days before the first of the month in a common year
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // residue mod 7 by octal digit sum, then a short subtract chain
    function automatic logic [2:0] mod7(input logic [14:0] x);
        logic [5:0] s;
        s = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
        if (s >= 6'd28) s = s - 6'd28;
        if (s >= 6'd14) s = s - 6'd14;
        if (s >= 6'd7)  s = s - 6'd7;
        return s[2:0];
    endfunction

endpackage

// ===== rtl/rno_front.sv =====
// first two pipeline stages: quotients, compares, validation, weekday sums
// depends on rno_pkg
module rno_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [1:0]        i_rule,
    input  logic              i_sched_valid,
    input  logic [13:0]       i_sched_year,
    input  logic [3:0]        i_sched_month,
    input  logic [4:0]        i_sched_day,
    input  logic [26:0]       i_sched_msec,
    input  logic              i_after_valid,
    input  logic [13:0]       i_after_year,
    input  logic [3:0]        i_after_month,
    input  logic [4:0]        i_after_day,
    input  logic [26:0]       i_after_msec,
    output logic              o_valid,
    output rno_pkg::t_p2      o_p2
);

    logic          r_v1, r_v2;
    rno_pkg::t_p1  r_p1, n_p1;
    rno_pkg::t_p2  r_p2, n_p2;
    logic [24:0]   s_pq100, a_pq100;
    logic [20:0]   s_pq400, a_pq400;

    // stage 1: year quotients by reciprocal multiply, ordering compares
    always_comb begin
        s_pq100 = 25'(i_sched_year[13:2]) * 25'(rno_pkg::RECIP_25);
        a_pq100 = 25'(i_after_year[13:2]) * 25'(rno_pkg::RECIP_25);
        s_pq400 = 21'(i_sched_year[13:4]) * 21'(rno_pkg::RECIP_25);
        a_pq400 = 21'(i_after_year[13:4]) * 21'(rno_pkg::RECIP_25);
        n_p1.ok_pre    = i_sched_valid && i_after_valid && (i_rule != rno_pkg::RULE_NONE);
        n_p1.rule      = rno_pkg::t_rule'(i_rule);
        n_p1.later     = {i_sched_year, i_sched_month, i_sched_day, i_sched_msec}
                       > {i_after_year, i_after_month, i_after_day, i_after_msec};
        n_p1.mon_after = {i_after_year, i_after_month} > {i_sched_year, i_sched_month};
        n_p1.tod_gt    = i_sched_msec > i_after_msec;
        n_p1.s.y    = i_sched_year;
        n_p1.s.m    = i_sched_month;
        n_p1.s.d    = i_sched_day;
        n_p1.s.ms   = i_sched_msec;
        n_p1.s.q100 = s_pq100[22:15];
        n_p1.s.q400 = s_pq400[20:15];
        n_p1.a.y    = i_after_year;
        n_p1.a.m    = i_after_month;
        n_p1.a.d    = i_after_day;
        n_p1.a.ms   = i_after_msec;
        n_p1.a.q100 = a_pq100[22:15];
        n_p1.a.q400 = a_pq400[20:15];
    end

    // stage 2: leap years, validity, weekday sums, monthly advance decision
    logic        s_leap, a_leap, s_ok, a_ok;
    logic [4:0]  s_ml, a_ml, td;
    logic [14:0] s_wk, a_wk;

    always_comb begin
        s_leap = (r_p1.s.y[1:0] == 2'd0) &&
                 (((14'(r_p1.s.q100) * 14'd100) != r_p1.s.y) || (r_p1.s.q100[1:0] == 2'd0));
        a_leap = (r_p1.a.y[1:0] == 2'd0) &&
                 (((14'(r_p1.a.q100) * 14'd100) != r_p1.a.y) || (r_p1.a.q100[1:0] == 2'd0));
        s_ml = rno_pkg::month_len(r_p1.s.m, s_leap);
        a_ml = rno_pkg::month_len(r_p1.a.m, a_leap);
        s_ok = (r_p1.s.y >= 14'd1) && (r_p1.s.y <= rno_pkg::MAX_YEAR) &&
               (r_p1.s.d >= 5'd1) && (r_p1.s.d <= s_ml) && (r_p1.s.ms < rno_pkg::MS_PER_DAY);
        a_ok = (r_p1.a.y >= 14'd1) && (r_p1.a.y <= rno_pkg::MAX_YEAR) &&
               (r_p1.a.d >= 5'd1) && (r_p1.a.d <= a_ml) && (r_p1.a.ms < rno_pkg::MS_PER_DAY);
        // running day count mod 7 only matters, and 365 is 1 mod 7
        s_wk = 15'(r_p1.s.y) + 15'(r_p1.s.y[13:2]) + 15'(r_p1.s.q400)
             + 15'(rno_pkg::cum_days(r_p1.s.m)) + 15'(r_p1.s.d) + rno_pkg::WK_BIAS
             - 15'(r_p1.s.q100) - 15'(s_leap && (r_p1.s.m <= 4'd2));
        a_wk = 15'(r_p1.a.y) + 15'(r_p1.a.y[13:2]) + 15'(r_p1.a.q400)
             + 15'(rno_pkg::cum_days(r_p1.a.m)) + 15'(r_p1.a.d) + rno_pkg::WK_BIAS
             - 15'(r_p1.a.q100) - 15'(a_leap && (r_p1.a.m <= 4'd2));
        td = (r_p1.s.d > a_ml) ? a_ml : r_p1.s.d;
        n_p2.found   = r_p1.ok_pre && s_ok && a_ok;
        n_p2.rule    = r_p1.rule;
        n_p2.later   = r_p1.later;
        n_p2.tod_gt  = r_p1.tod_gt;
        n_p2.sy      = r_p1.s.y;
        n_p2.sm      = r_p1.s.m;
        n_p2.sd      = r_p1.s.d;
        n_p2.sms     = r_p1.s.ms;
        n_p2.ay      = r_p1.a.y;
        n_p2.am      = r_p1.a.m;
        n_p2.ad      = r_p1.a.d;
        n_p2.ml_a    = a_ml;
        n_p2.leap_a  = a_leap;
        n_p2.wk_s    = s_wk;
        n_p2.wk_a    = a_wk;
        n_p2.mon_adv = !r_p1.mon_after ||
                       !((td > r_p1.a.d) || ((td == r_p1.a.d) && r_p1.tod_gt));
    end

    // stage registers, valid bits cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= n_p1;
            r_p2 <= n_p2;
        end
    end

    assign o_valid = r_v2;
    assign o_p2    = r_p2;

endmodule

// ===== rtl/rno_back.sv =====
// last two pipeline stages: step selection, date advance, saturation, result register
// depends on rno_pkg
module rno_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  rno_pkg::t_p2      i_p2,
    output logic              o_valid,
    output rno_pkg::t_res     o_res
);

    logic          r_v3, r_v4;
    rno_pkg::t_p3  r_p3, n_p3;
    rno_pkg::t_res r_res, n_res;
    logic [2:0]    ws, wa;
    logic [3:0]    r7;

    // stage 3: weekday distance, day step, monthly target month
    always_comb begin
        ws = rno_pkg::mod7(i_p2.wk_s);
        wa = rno_pkg::mod7(i_p2.wk_a);
        r7 = 4'(wa) + 4'd7 - 4'(ws);
        if (r7 >= 4'd7) r7 = r7 - 4'd7;
        n_p3.found  = i_p2.found;
        n_p3.rule   = i_p2.rule;
        n_p3.later  = i_p2.later;
        n_p3.sy     = i_p2.sy;
        n_p3.sm     = i_p2.sm;
        n_p3.sd     = i_p2.sd;
        n_p3.sms    = i_p2.sms;
        n_p3.ay     = i_p2.ay;
        n_p3.am     = i_p2.am;
        n_p3.ad     = i_p2.ad;
        n_p3.ml_a   = i_p2.ml_a;
        n_p3.leap_a = i_p2.leap_a;
        if (i_p2.rule == rno_pkg::RULE_WEEKLY) begin
            if (r7 != 4'd0) n_p3.delta = 4'd7 - r7;
            else            n_p3.delta = i_p2.tod_gt ? 4'd0 : 4'd7;
        end else begin
            n_p3.delta = i_p2.tod_gt ? 4'd0 : 4'd1;
        end
        n_p3.ty     = i_p2.ay;
        n_p3.tm     = i_p2.am;
        n_p3.yr_inc = 1'b0;
        if (i_p2.mon_adv) begin
            if (i_p2.am == 4'd12) begin
                n_p3.ty     = i_p2.ay + 14'd1;
                n_p3.tm     = 4'd1;
                n_p3.yr_inc = 1'b1;
            end else begin
                n_p3.tm = i_p2.am + 4'd1;
            end
        end
    end

    // stage 4: add the day step with month and year carry, clamp monthly anchor, saturate past MAX_YEAR
    logic [5:0]  nd;
    logic [13:0] y4;
    logic [3:0]  m4;
    logic [4:0]  d4, tml;

    always_comb begin
        nd  = 6'(r_p3.ad) + 6'(r_p3.delta);
        tml = rno_pkg::month_len(r_p3.tm, r_p3.leap_a && !r_p3.yr_inc);
        if (r_p3.rule == rno_pkg::RULE_MONTHLY) begin
            y4 = r_p3.ty;
            m4 = r_p3.tm;
            d4 = (r_p3.sd > tml) ? tml : r_p3.sd;
        end else if (nd > 6'(r_p3.ml_a)) begin
            d4 = 5'(nd - 6'(r_p3.ml_a));
            if (r_p3.am == 4'd12) begin
                y4 = r_p3.ay + 14'd1;
                m4 = 4'd1;
            end else begin
                y4 = r_p3.ay;
                m4 = r_p3.am + 4'd1;
            end
        end else begin
            y4 = r_p3.ay;
            m4 = r_p3.am;
            d4 = nd[4:0];
        end
        n_res = '0;
        if (r_p3.found) begin
            n_res.found = 1'b1;
            if (r_p3.later) begin
                n_res.y  = r_p3.sy;
                n_res.m  = r_p3.sm;
                n_res.d  = r_p3.sd;
                n_res.ms = r_p3.sms;
            end else if (y4 > rno_pkg::MAX_YEAR) begin
                n_res.y  = rno_pkg::MAX_YEAR;
                n_res.m  = 4'd12;
                n_res.d  = 5'd31;
                n_res.ms = rno_pkg::MS_PER_DAY - 27'd1;
            end else begin
                n_res.y  = y4;
                n_res.m  = m4;
                n_res.d  = d4;
                n_res.ms = r_p3.sms;
            end
        end
    end

    // stage registers, valid bits cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p3  <= n_p3;
            r_res <= n_res;
        end
    end

    assign o_valid = r_v4;
    assign o_res   = r_res;

endmodule

// ===== rtl/recurrence_next_occurrence_core.sv =====
// Next occurrence of a daily, weekly or monthly recurring event after a reference
// instant. Four-stage pipeline: one query is accepted every cycle while the output
// is not stalled; its result beat is registered at every stage, last in the output
// register. All stages advance together whenever the output register is empty or
// its beat is taken, so a stalled output holds every stage in place and the input
// is ready whenever the output slot frees up. Each query gives exactly one result beat.
// depends on rno_pkg, rno_front, rno_back
module recurrence_next_occurrence_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_rule,
    input  logic        i_sched_valid,
    input  logic [13:0] i_sched_year,
    input  logic [3:0]  i_sched_month,
    input  logic [4:0]  i_sched_day,
    input  logic [26:0] i_sched_msec,
    input  logic        i_after_valid,
    input  logic [13:0] i_after_year,
    input  logic [3:0]  i_after_month,
    input  logic [4:0]  i_after_day,
    input  logic [26:0] i_after_msec,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [13:0] o_next_year,
    output logic [3:0]  o_next_month,
    output logic [4:0]  o_next_day,
    output logic [26:0] o_next_msec
);

    logic          en, v2;
    rno_pkg::t_p2  p2;
    rno_pkg::t_res res;

    // pipeline moves when the output slot is free or being drained
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    rno_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_valid),
        .i_rule        (i_rule),
        .i_sched_valid (i_sched_valid),
        .i_sched_year  (i_sched_year),
        .i_sched_month (i_sched_month),
        .i_sched_day   (i_sched_day),
        .i_sched_msec  (i_sched_msec),
        .i_after_valid (i_after_valid),
        .i_after_year  (i_after_year),
        .i_after_month (i_after_month),
        .i_after_day   (i_after_day),
        .i_after_msec  (i_after_msec),
        .o_valid       (v2),
        .o_p2          (p2)
    );

    rno_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v2),
        .i_p2    (p2),
        .o_valid (o_valid),
        .o_res   (res)
    );

    assign o_found      = res.found;
    assign o_next_year  = res.y;
    assign o_next_month = res.m;
    assign o_next_day   = res.d;
    assign o_next_msec  = res.ms;

endmodule
